>>> sv/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the IPv4 receive header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam int ADDR_BYTES = 4;
    localparam int SRC_START  = 12;
    localparam int DST_START  = SRC_START + ADDR_BYTES;
    localparam int HDR_END    = DST_START + ADDR_BYTES;

    localparam int POS_W  = 5;
    localparam int ADDR_W = 8 * ADDR_BYTES;
    localparam int AIDX_W = $clog2(ADDR_BYTES);

    localparam logic [7:0]  VERSION_MASK = 8'hF0;
    localparam logic [7:0]  VERSION_IPV4 = 8'h40;
    localparam logic [7:0]  IHL_MASK     = 8'h0F;
    localparam logic [7:0]  IHL_MIN      = 8'h05;
    localparam logic [12:0] FRAG_MASK    = 13'h1FFF;
    localparam logic [15:0] CSUM_GOOD    = 16'hFFFF;
    localparam logic [15:0] HDR_LEN      = 16'(HDR_END);

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [3:0] {
        VERDICT_ICMP      = 4'd0,
        VERDICT_UDP       = 4'd1,
        VERDICT_TCP       = 4'd2,
        VERDICT_UNKNOWN   = 4'd3,
        VERDICT_BAD_VER   = 4'd4,
        VERDICT_OPTIONS   = 4'd5,
        VERDICT_FRAGMENT  = 4'd6,
        VERDICT_BAD_CSUM  = 4'd7,
        VERDICT_NOT_OURS  = 4'd8
    } t_verdict;

    // Collected header summary, handed from the front to the back.
    typedef struct packed {
        logic [7:0]        vl_byte;
        logic [12:0]       frag_off;
        logic [15:0]       csum;
        logic              addr_match;
        logic [7:0]        protocol;
        logic [15:0]       total_len;
        logic [ADDR_W-1:0] src_addr;
    } t_hdr_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> sv/ihc_front.sv
// ----------------------------------------------------------------------------
// ihc_front
// Byte collector: tracks position, gathers header fields, runs the checksum
// and destination compare, and emits one summary per complete header.
// ----------------------------------------------------------------------------
module ihc_front
    import ihc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_wr_data,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    output logic              o_push,
    output t_hdr_rec          o_rec
);

    logic [ADDR_W-1:0] r_local_addr;
    logic [POS_W-1:0]  r_pos;
    logic              r_active;
    logic [7:0]        r_hold;
    logic [15:0]       r_sum;
    logic              r_match;
    t_hdr_rec          r_rec;

    logic [POS_W-1:0]  pos_eff;
    logic              active_eff;
    logic [15:0]       sum_eff;
    logic              match_eff;
    logic [16:0]       sum_wide;
    logic [AIDX_W-1:0] dst_idx;
    logic [7:0]        dst_byte;
    logic              last_byte;

    logic [POS_W-1:0]  n_pos;
    logic              n_active;
    logic [7:0]        n_hold;
    logic [15:0]       n_sum;
    logic              n_match;
    t_hdr_rec          n_rec;

    // A first byte restarts the header regardless of where we are.
    assign active_eff = i_first | r_active;
    assign pos_eff    = i_first ? '0 : r_pos;
    assign sum_eff    = i_first ? '0 : r_sum;
    assign match_eff  = i_first ? 1'b1 : r_match;

    assign sum_wide  = {1'b0, sum_eff} + {1'b0, r_hold, i_byte};
    assign dst_idx   = AIDX_W'(ADDR_BYTES - 1) - AIDX_W'(pos_eff - POS_W'(DST_START));
    assign dst_byte  = r_local_addr[8*dst_idx +: 8];
    assign last_byte = (pos_eff == POS_W'(HDR_END - 1));

    always_comb begin
        n_pos    = r_pos;
        n_active = r_active;
        n_hold   = r_hold;
        n_sum    = r_sum;
        n_match  = r_match;
        n_rec    = r_rec;
        if (i_accept && active_eff) begin
            n_sum   = sum_eff;
            n_match = match_eff;
            // Even bytes are word high halves; fold the word in on odd bytes.
            if (!pos_eff[0]) begin
                n_hold = i_byte;
            end else begin
                n_sum = sum_wide[15:0] + 16'(sum_wide[16]);
            end
            if (pos_eff == POS_W'(0)) begin
                n_rec.vl_byte = i_byte;
            end else if (pos_eff == POS_W'(2)) begin
                n_rec.total_len[15:8] = i_byte;
            end else if (pos_eff == POS_W'(3)) begin
                n_rec.total_len[7:0] = i_byte;
            end else if (pos_eff == POS_W'(6)) begin
                n_rec.frag_off[12:8] = i_byte[4:0];
            end else if (pos_eff == POS_W'(7)) begin
                n_rec.frag_off[7:0] = i_byte;
            end else if (pos_eff == POS_W'(9)) begin
                n_rec.protocol = i_byte;
            end else if (pos_eff >= POS_W'(SRC_START) && pos_eff < POS_W'(DST_START)) begin
                n_rec.src_addr = {n_rec.src_addr[ADDR_W-9:0], i_byte};
            end else if (pos_eff >= POS_W'(DST_START) && pos_eff < POS_W'(HDR_END)) begin
                if (dst_byte != i_byte) begin
                    n_match = 1'b0;
                end
            end
            n_pos    = pos_eff + POS_W'(1);
            n_active = !last_byte;
            n_rec.csum       = n_sum;
            n_rec.addr_match = n_match;
        end
    end

    assign o_push = i_accept && active_eff && last_byte;
    assign o_rec  = n_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
            r_pos        <= '0;
            r_active     <= 1'b0;
            r_hold       <= '0;
            r_sum        <= '0;
            r_match      <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_local_addr <= i_cfg_wr_data;
            end
            r_pos    <= n_pos;
            r_active <= n_active;
            r_hold   <= n_hold;
            r_sum    <= n_sum;
            r_match  <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

>>> sv/ihc_queue.sv
// ----------------------------------------------------------------------------
// ihc_queue
// Two-entry queue of header summaries between the front and the back.
// ----------------------------------------------------------------------------
module ihc_queue
    import ihc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_hdr_rec  i_rec,
    input  logic      i_pop,
    output t_hdr_rec  o_rec,
    output t_q_status o_status
);

    t_hdr_rec   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

>>> sv/ihc_back.sv
// ----------------------------------------------------------------------------
// ihc_back
// Verdict stage: applies the header checks in priority order, computes the
// payload length and holds the result item until the receiver takes it.
// ----------------------------------------------------------------------------
module ihc_back
    import ihc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hdr_rec          i_rec,
    input  logic              i_avail,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output t_verdict          o_verdict,
    output logic [7:0]        o_protocol,
    output logic [15:0]       o_payload_len,
    output logic [ADDR_W-1:0] o_src_addr
);

    logic              r_valid;
    t_verdict          r_verdict;
    logic [7:0]        r_protocol;
    logic [15:0]       r_payload_len;
    logic [ADDR_W-1:0] r_src_addr;

    t_verdict          n_verdict;
    logic [15:0]       n_payload_len;

    assign o_pop = i_avail && (!r_valid || i_ready);

    always_comb begin
        priority if ((i_rec.vl_byte & VERSION_MASK) != VERSION_IPV4) begin
            n_verdict = VERDICT_BAD_VER;
        end else if ((i_rec.vl_byte & IHL_MASK) != IHL_MIN) begin
            n_verdict = VERDICT_OPTIONS;
        end else if ((i_rec.frag_off & FRAG_MASK) != '0) begin
            n_verdict = VERDICT_FRAGMENT;
        end else if (i_rec.csum != CSUM_GOOD) begin
            n_verdict = VERDICT_BAD_CSUM;
        end else if (!i_rec.addr_match) begin
            n_verdict = VERDICT_NOT_OURS;
        end else if (i_rec.protocol == PROTO_ICMP) begin
            n_verdict = VERDICT_ICMP;
        end else if (i_rec.protocol == PROTO_UDP) begin
            n_verdict = VERDICT_UDP;
        end else if (i_rec.protocol == PROTO_TCP) begin
            n_verdict = VERDICT_TCP;
        end else begin
            n_verdict = VERDICT_UNKNOWN;
        end
    end

    // Saturate at zero for short total lengths.
    assign n_payload_len = (i_rec.total_len > HDR_LEN) ? (i_rec.total_len - HDR_LEN) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict     <= n_verdict;
            r_protocol    <= i_rec.protocol;
            r_payload_len <= n_payload_len;
            r_src_addr    <= i_rec.src_addr;
        end
    end

    assign o_valid       = r_valid;
    assign o_verdict     = r_verdict;
    assign o_protocol    = r_protocol;
    assign o_payload_len = r_payload_len;
    assign o_src_addr    = r_src_addr;

endmodule

>>> sv/ipv4_receive_header_checker.sv
// ----------------------------------------------------------------------------
// ipv4_receive_header_checker
// Checks received IPv4 headers byte by byte and reports one verdict each.
// ----------------------------------------------------------------------------
// Input stream: one header byte per item on s_axis_tdata; s_axis_tuser high
// marks byte 0 of a new header and drops any partial one. Bytes outside a
// header (after byte 19, or before any first byte) are taken and ignored.
// Output stream: one item per complete 20-byte header. m_axis_tuser carries
// the verdict; m_axis_tdata carries protocol, payload length and source.
// Configuration: i_cfg_wr_en writes the own address from i_cfg_wr_data.
// Throughput: one byte per cycle while s_axis_tready is high. The front collector handles one
// byte a cycle; a two-entry summary queue separates it from the verdict stage.
// Output path: the summary is queued as byte 19 is taken, then registered into the result.
// Stall: while m_axis_tready is low the result holds; the queue absorbs two
// further headers, after which s_axis_tready drops until an entry frees.
// Reset (i_rst_n low, synchronous): no header active, queue and output empty,
// own address cleared to zero.
// ----------------------------------------------------------------------------
module ipv4_receive_header_checker
    import ihc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] header_byte
    input  logic              s_axis_tuser,   // [0] first_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,   // [7:0] protocol_field,
                                              // [23:8] payload_length,
                                              // [55:24] source_address
    output logic [3:0]        m_axis_tuser    // [3:0] verdict
);

    logic              in_accept;
    logic              push;
    logic              pop;
    t_hdr_rec          front_rec;
    t_hdr_rec          back_rec;
    t_q_status         q_status;
    t_verdict          verdict;
    logic [7:0]        protocol;
    logic [15:0]       payload_len;
    logic [ADDR_W-1:0] src_addr;

    assign s_axis_tready = !q_status.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    ihc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_byte        (s_axis_tdata),
        .i_first       (s_axis_tuser),
        .o_push        (push),
        .o_rec         (front_rec)
    );

    ihc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (front_rec),
        .i_pop    (pop),
        .o_rec    (back_rec),
        .o_status (q_status)
    );

    ihc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (back_rec),
        .i_avail       (!q_status.empty),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_verdict     (verdict),
        .o_protocol    (protocol),
        .o_payload_len (payload_len),
        .o_src_addr    (src_addr)
    );

    assign m_axis_tuser = verdict;
    assign m_axis_tdata = {src_addr, payload_len, protocol};

    // A finished header must always find room in the queue.
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("header summary pushed into full queue");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_status.empty)
        else $error("queue empty after push");

    a_pop_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> m_axis_tvalid)
        else $error("output not valid after pop");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= VERDICT_NOT_OURS))
        else $error("verdict code out of range");

    a_payload_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:8] <= 16'hFFFF - HDR_LEN))
        else $error("payload length beyond limit");

endmodule
